### rtl/sfa_pkg.sv
// Package for the spring force accumulator: payload structs, widths, constants.
// No dependencies.
package sfa_pkg;

  localparam int FracBits = 16;

  typedef struct packed {
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] node_z;
    logic signed [31:0] far_x;
    logic signed [31:0] far_y;
    logic signed [31:0] far_z;
    logic [31:0]        rest_length;
    logic [31:0]        stiffness;
    logic               spring_present;
    logic               last_spring;
  } sfa_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               degenerate_seen;
    logic               saturated;
  } sfa_out_t;

  // classified spring, handed from front to back through the queue
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [31:0]        rest;
    logic [31:0]        k;
    logic               add;   // present and nonzero length
    logic               degen; // present, zero length
    logic               last;
  } sfa_job_t;

endpackage

### rtl/sfa_front.sv
// Front end: accepts springs, forms displacements and classifies them.
// Depends on sfa_pkg.
module sfa_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfa_pkg::sfa_in_t  in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output sfa_pkg::sfa_job_t job_data
);

  logic              full_r;
  sfa_pkg::sfa_job_t job_r;
  logic signed [32:0] dx, dy, dz;

  assign in_ready  = !full_r || job_ready;
  assign job_valid = full_r;
  assign job_data  = job_r;

  assign dx = 33'(in_data.node_x) - 33'(in_data.far_x);
  assign dy = 33'(in_data.node_y) - 33'(in_data.far_y);
  assign dz = 33'(in_data.node_z) - 33'(in_data.far_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      full_r <= 1'b1;
    end else if (job_ready) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job_r.dx    <= dx;
      job_r.dy    <= dy;
      job_r.dz    <= dz;
      job_r.rest  <= in_data.rest_length;
      job_r.k     <= in_data.stiffness;
      job_r.add   <= in_data.spring_present && (dx != '0 || dy != '0 || dz != '0);
      job_r.degen <= in_data.spring_present && dx == '0 && dy == '0 && dz == '0;
      job_r.last  <= in_data.last_spring;
    end
  end

endmodule

### rtl/sfa_queue.sv
// Two-entry job queue between front and back ends.
// Depends on sfa_pkg.
module sfa_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  sfa_pkg::sfa_job_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output sfa_pkg::sfa_job_t rd_data
);

  sfa_pkg::sfa_job_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

endmodule

### rtl/sfa_back.sv
// Back end: square root, tension, per-axis unit divide and saturating sum.
// Depends on sfa_pkg.
module sfa_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  sfa_pkg::sfa_job_t job_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sfa_pkg::sfa_out_t out_data
);

  localparam int F = sfa_pkg::FracBits;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SQ   = 8'b0000_0010,
    S_SQRT = 8'b0000_0100,
    S_TEN  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_ACC  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  sfa_pkg::sfa_job_t job_r;

  logic [1:0]  step_r;        // sub-step / axis index
  logic [5:0]  cnt_r;
  logic [65:0] sq_r;          // sum of squares, shifted out two bits a step
  logic [65:0] rem_r;
  logic [32:0] root_r;
  logic [64:0] tension_r;
  logic        str_pos_r;
  logic [32:0] str_mag_r;
  logic [32+F:0] num_r;       // dividend |d|<<F, shifted out
  logic [32:0] drem_r;
  logic [32+F:0] quo_r;
  logic [34:0] mag_r;
  logic signed [31:0] sum_r [3];
  logic        zflag_r, sflag_r;
  sfa_pkg::sfa_out_t res_r;
  logic        res_full_r;

  logic signed [32:0] d_cur;
  logic [32:0] d_abs;
  logic [65:0] rem_sh, trial;
  logic [33:0] drem_sh;
  logic [65:0] prod;
  logic signed [34:0] stretch;
  logic [32:0] sel_sq_abs;
  logic signed [35:0] acc_nxt;
  logic        neg;
  logic        res_load;

  function automatic logic [32:0] d_abs_of0(input logic signed [32:0] d);
    return d[32] ? 33'(-d) : d;
  endfunction

  function automatic logic [32:0] d_abs_next(input sfa_pkg::sfa_job_t j,
                                             input logic [1:0] s);
    return (s == 2'd0) ? d_abs_of0(j.dy) : d_abs_of0(j.dz);
  endfunction

  always_comb begin
    unique case (step_r)
      2'd0:    d_cur = job_r.dx;
      2'd1:    d_cur = job_r.dy;
      default: d_cur = job_r.dz;
    endcase
    d_abs = d_cur[32] ? 33'(-d_cur) : d_cur;
  end

  assign sel_sq_abs = d_abs;
  assign rem_sh  = {rem_r[63:0], sq_r[65:64]};
  assign trial   = {31'd0, root_r, 2'b01};
  assign drem_sh = {drem_r, num_r[32+F]};
  assign stretch = 35'($signed({2'b00, root_r})) - 35'($signed({3'b000, job_r.rest}));

  // shared 33x33 multiplier: squares, then tension halves, then tension*unit
  logic [32:0] ma, mb;
  always_comb begin
    ma = sel_sq_abs;
    mb = sel_sq_abs;
    if (state_r == S_TEN) begin
      ma = {1'b0, job_r.k};
      mb = (step_r == 2'd0) ? {32'd0, str_mag_r[32]} : {1'b0, str_mag_r[31:0]};
    end else if (state_r == S_MUL) begin
      ma = (cnt_r == 6'd0) ? 33'(tension_r[64:32]) : {1'b0, tension_r[31:0]};
      mb = quo_r[32:0];
    end
    prod = ma * mb;
  end

  assign neg = str_pos_r == !d_cur[32];
  assign acc_nxt = neg ? 36'(sum_r[step_r]) - 36'(mag_r) : 36'(sum_r[step_r]) + 36'(mag_r);

  assign job_ready = state_r == S_IDLE;
  assign out_valid = res_full_r;
  assign out_data  = res_r;
  assign res_load  = state_r == S_OUT && job_r.last && (!res_full_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (job_valid) state_nxt = S_SQ;
      S_SQ:   if (step_r == 2'd2) state_nxt = job_r.add ? S_SQRT : S_OUT;
      S_SQRT: if (cnt_r == 6'd32) state_nxt = S_TEN;
      S_TEN:  if (step_r == 2'd1) state_nxt = (stretch == '0) ? S_OUT : S_DIV;
      S_DIV:  if (d_cur == '0 || cnt_r == 6'(32 + F)) state_nxt = (d_cur == '0) ? S_ACC : S_MUL;
      S_MUL:  if (cnt_r == 6'd1) state_nxt = S_ACC;
      S_ACC:  if (step_r == 2'd2) state_nxt = S_OUT;
              else state_nxt = S_DIV;
      S_OUT:  if (!job_r.last || !res_full_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      res_full_r <= 1'b0;
      sum_r[0]   <= '0;
      sum_r[1]   <= '0;
      sum_r[2]   <= '0;
      zflag_r    <= 1'b0;
      sflag_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) res_full_r <= 1'b1;
      else if (out_ready) res_full_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (job_valid) begin
          job_r  <= job_data;
          step_r <= 2'd0;
          sq_r   <= '0;
        end
        S_SQ: begin
          sq_r   <= sq_r + prod;
          step_r <= step_r + 2'd1;
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= '0;
          if (job_r.degen) zflag_r <= 1'b1;
        end
        S_SQRT: begin
          sq_r <= {sq_r[63:0], 2'b00};
          cnt_r <= cnt_r + 6'd1;
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[31:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[31:0], 1'b0};
          end
          step_r <= 2'd0;
          str_pos_r <= 1'b0;
        end
        S_TEN: begin
          if (step_r == 2'd0) begin
            str_pos_r <= !stretch[34];
            str_mag_r <= 33'(stretch[34] ? -stretch : stretch);
            step_r    <= 2'd1;
          end else begin
            // (k*a_hi)<<(32-F) + (k*a_lo)>>F
            tension_r <= (65'(str_mag_r[32] ? {1'b0, job_r.k} : 33'd0) << (32 - F))
                         + 65'(prod[63:F]);
            step_r    <= 2'd0;
            cnt_r     <= '0;
            num_r     <= {d_abs_of0(job_r.dx), {F{1'b0}}};
            drem_r    <= '0;
            quo_r     <= '0;
          end
        end
        S_DIV: begin
          if (d_cur != '0) begin
            num_r <= {num_r[31+F:0], 1'b0};
            cnt_r <= (cnt_r == 6'(32 + F)) ? 6'd0 : cnt_r + 6'd1;
            if (drem_sh >= {1'b0, root_r}) begin
              drem_r <= 33'(drem_sh - {1'b0, root_r});
              quo_r  <= {quo_r[31+F:0], 1'b1};
            end else begin
              drem_r <= drem_sh[32:0];
              quo_r  <= {quo_r[31+F:0], 1'b0};
            end
          end
          mag_r <= '0;
        end
        S_MUL: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd0) begin
            // high tension half times unit
            if (prod[65:F-1] != '0) mag_r <= 35'h2_0000_0000;
            else mag_r <= 35'(prod[F-2:0]) << (32 - F);
          end else begin
            if (mag_r != 35'h2_0000_0000) mag_r <= 35'(mag_r + 35'(prod[63:F]));
          end
        end
        S_ACC: begin
          if (d_cur != '0 && mag_r != '0) begin
            if (acc_nxt > 36'sd2147483647) begin
              sum_r[step_r] <= 32'sh7fffffff; sflag_r <= 1'b1;
            end else if (acc_nxt < -36'sd2147483648) begin
              sum_r[step_r] <= 32'sh80000000; sflag_r <= 1'b1;
            end else sum_r[step_r] <= acc_nxt[31:0];
          end
          step_r <= step_r + 2'd1;
          cnt_r  <= '0;
          drem_r <= '0;
          quo_r  <= '0;
          num_r  <= {d_abs_next(job_r, step_r), {F{1'b0}}};
        end
        S_OUT: if (res_load) begin
          res_r.force_x <= sum_r[0];
          res_r.force_y <= sum_r[1];
          res_r.force_z <= sum_r[2];
          res_r.degenerate_seen <= zflag_r;
          res_r.saturated <= sflag_r;
          sum_r[0] <= '0; sum_r[1] <= '0; sum_r[2] <= '0;
          zflag_r <= 1'b0; sflag_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/spring_force_accumulator_core.sv
// Spring force accumulator top level: front end, job queue, back end; needs sfa_pkg.
// The result becomes valid only after the last spring's transfer. The back end takes
// one job at a time: square root and tension, then a divide and multiply per nonzero
// axis; a zero axis skips the divide and multiply, a zero-stretch spring skips the axes, and
// an empty or zero-length spring skips all of it. Front register and queue buffer 3 springs.
// Synchronous active-low reset clears the sums, flags, queue and result valid flag.
module spring_force_accumulator_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfa_pkg::sfa_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sfa_pkg::sfa_out_t out_data
);

  logic f_valid, f_ready, q_valid, q_ready;
  sfa_pkg::sfa_job_t f_job, q_job;

  sfa_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid(f_valid), .job_ready(f_ready), .job_data(f_job));

  sfa_queue u_queue (.clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data(f_job), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job));

  sfa_back u_back (.clk, .rst_n, .job_valid(q_valid), .job_ready(q_ready),
    .job_data(q_job), .out_valid, .out_ready, .out_data);

endmodule
